// ===== rtl/imconv5_pkg.sv =====
// Shared types and constants of the 5x5 image convolution block.
// No dependencies; the other files, all but imconv5_ram, refer to it by scoped names.
package imconv5_pkg;

    localparam int PIX_W       = 8;
    localparam int BYTE_W      = 8;
    localparam int KROW_W      = 40;
    localparam int NUM_KROWS   = 5;
    localparam int SCALE_W     = 17;
    localparam int FRAC_W      = 16;
    localparam int SIZE_W      = 11;
    localparam int COUNT_W     = 21;
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 40;

    // Reset kernel: symmetric 5x5 Gaussian, column 0 in the low byte
    localparam logic [KROW_W-1:0] KROW_EDGE_RST   = 40'd8657372162;
    localparam logic [KROW_W-1:0] KROW_INNER_RST  = 40'd17331652868;
    localparam logic [KROW_W-1:0] KROW_CENTER_RST = 40'd21677149189;
    localparam logic [SCALE_W-1:0] SCALE_RST      = 17'd412;
    localparam logic [SIZE_W-1:0]  SIZE_RST       = 11'd1024;

    localparam logic [PIX_W-1:0] PIX_MAX = 8'hFF;

    typedef enum logic [0:0] {
        OP_PIXEL = 1'b0,
        OP_FLUSH = 1'b1
    } op_t;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_KROW0  = 3'd0,
        REG_KROW1  = 3'd1,
        REG_KROW2  = 3'd2,
        REG_KROW3  = 3'd3,
        REG_KROW4  = 3'd4,
        REG_SCALE  = 3'd5,
        REG_WIDTH  = 3'd6,
        REG_HEIGHT = 3'd7
    } reg_index_t;

    typedef logic [NUM_KROWS-1:0][KROW_W-1:0] krows_t;

    // Position flags that travel with a result
    typedef struct packed {
        logic eol;
        logic eof;
    } res_ctrl_t;

endpackage

// ===== rtl/imconv5_if.sv =====
// Handshake channels of the convolution block: pixel requests, results, config writes.
// Depends on imconv5_pkg for field widths.
interface imconv5_in_if;
    logic                           valid;
    logic                           ready;
    logic                           op;
    logic [imconv5_pkg::PIX_W-1:0]  pixel_in;

    modport source (output valid, output op, output pixel_in, input ready);
    modport sink   (input valid, input op, input pixel_in, output ready);
endinterface

interface imconv5_out_if;
    logic                           valid;
    logic                           ready;
    logic [imconv5_pkg::PIX_W-1:0]  pixel_out;
    logic                           end_of_line;
    logic                           end_of_frame;

    modport source (output valid, output pixel_out, output end_of_line,
                    output end_of_frame, input ready);
    modport sink   (input valid, input pixel_out, input end_of_line,
                    input end_of_frame, output ready);
endinterface

interface imconv5_cfg_if;
    logic                                 valid;
    logic                                 ready;
    logic [imconv5_pkg::CFG_INDEX_W-1:0]  index;
    logic [imconv5_pkg::CFG_DATA_W-1:0]   data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== rtl/imconv5_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port with registered data.
// No package dependencies.
module imconv5_ram #(
    parameter int DATA_W = 32,
    parameter int DEPTH  = 1024
) (
    input  logic                      clk,
    input  logic                      we,
    input  logic [$clog2(DEPTH)-1:0]  waddr,
    input  logic [DATA_W-1:0]         wdata,
    input  logic                      re,
    input  logic [$clog2(DEPTH)-1:0]  raddr,
    output logic [DATA_W-1:0]         rdata
);

    logic [DATA_W-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ===== rtl/imconv5_filter.sv =====
// Arithmetic pipeline: products, row sums, total, scaling and clamping, output register.
// Depends on imconv5_pkg and the result channel of imconv5_if.
module imconv5_filter #(
    parameter int KERNEL_SIZE = 5,
    parameter int COEF_BITS   = 8
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                push,
    output logic                                ready,
    input  logic [KERNEL_SIZE-1:0][KERNEL_SIZE-1:0][imconv5_pkg::PIX_W-1:0] win,
    input  imconv5_pkg::res_ctrl_t              ctrl,
    input  imconv5_pkg::krows_t                 krows,
    input  logic [imconv5_pkg::SCALE_W-1:0]     scale,
    imconv5_out_if.source                       results
);

    localparam int PIX_W  = imconv5_pkg::PIX_W;
    localparam int PROD_W = PIX_W + 1 + COEF_BITS;
    localparam int RSUM_W = PROD_W + $clog2(KERNEL_SIZE);
    localparam int SUM_W  = RSUM_W + $clog2(KERNEL_SIZE);
    localparam int MUL_W  = SUM_W - 1 + imconv5_pkg::SCALE_W;
    localparam int TOP_LO = imconv5_pkg::FRAC_W + PIX_W;

    logic signed [COEF_BITS-1:0] coef [KERNEL_SIZE][KERNEL_SIZE];
    logic signed [PROD_W-1:0]    prod_next [KERNEL_SIZE][KERNEL_SIZE];
    logic signed [PROD_W-1:0]    prod_reg  [KERNEL_SIZE][KERNEL_SIZE];
    logic signed [RSUM_W-1:0]    rsum_next [KERNEL_SIZE];
    logic signed [RSUM_W-1:0]    rsum_reg  [KERNEL_SIZE];
    logic signed [SUM_W-1:0]     sum_next;
    logic signed [SUM_W-1:0]     sum_reg;
    logic [SUM_W-2:0]            pos_sum;
    logic [MUL_W-1:0]            mul_next;
    logic [MUL_W-1:0]            mul_reg;
    logic [PIX_W-1:0]            pix_next;
    logic [PIX_W-1:0]            pix_reg;

    logic v2_reg, v3_reg, v4_reg, v5_reg, v6_reg;
    logic rdy2, rdy3, rdy4, rdy5, rdy6;
    imconv5_pkg::res_ctrl_t ctrl2_reg, ctrl3_reg, ctrl4_reg, ctrl5_reg, ctrl6_reg;

    // Backward ready chain: a stage loads when it is empty or its successor loads
    assign rdy6  = !v6_reg || results.ready;
    assign rdy5  = !v5_reg || rdy6;
    assign rdy4  = !v4_reg || rdy5;
    assign rdy3  = !v3_reg || rdy4;
    assign rdy2  = !v2_reg || rdy3;
    assign ready = rdy2;

    // Unpack signed coefficients from the low bits of each byte
    always_comb
    begin
        for (int i = 0; i < KERNEL_SIZE; i++)
        begin
            for (int k = 0; k < KERNEL_SIZE; k++)
            begin
                coef[i][k] = $signed(krows[i][imconv5_pkg::BYTE_W*k +: COEF_BITS]);
            end
        end
    end

    // One product per tap
    always_comb
    begin
        for (int i = 0; i < KERNEL_SIZE; i++)
        begin
            for (int k = 0; k < KERNEL_SIZE; k++)
            begin
                prod_next[i][k] = PROD_W'(signed'({1'b0, win[i][k]}))
                                * PROD_W'(coef[i][k]);
            end
        end
    end

    // Sum each kernel row
    always_comb
    begin
        for (int i = 0; i < KERNEL_SIZE; i++)
        begin
            rsum_next[i] = '0;
            for (int k = 0; k < KERNEL_SIZE; k++)
            begin
                rsum_next[i] = rsum_next[i] + RSUM_W'(prod_reg[i][k]);
            end
        end
    end

    // Sum the row totals
    always_comb
    begin
        sum_next = '0;
        for (int i = 0; i < KERNEL_SIZE; i++)
        begin
            sum_next = sum_next + SUM_W'(rsum_reg[i]);
        end
    end

    // Drop non-positive sums, then scale
    assign pos_sum  = (!sum_reg[SUM_W-1] && (sum_reg != '0)) ? sum_reg[SUM_W-2:0] : '0;
    assign mul_next = MUL_W'(pos_sum) * MUL_W'(scale);

    // Truncate the fraction and clamp to the pixel range
    assign pix_next = (|mul_reg[MUL_W-1:TOP_LO]) ? imconv5_pkg::PIX_MAX
                                                 : mul_reg[TOP_LO-1:imconv5_pkg::FRAC_W];

    // Stage valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
            v6_reg <= 1'b0;
        end
        else
        begin
            if (rdy2) v2_reg <= push;
            if (rdy3) v3_reg <= v2_reg;
            if (rdy4) v4_reg <= v3_reg;
            if (rdy5) v5_reg <= v4_reg;
            if (rdy6) v6_reg <= v5_reg;
        end
    end

    // Stage payloads
    always_ff @(posedge clk)
    begin
        if (rdy2)
        begin
            prod_reg  <= prod_next;
            ctrl2_reg <= ctrl;
        end
        if (rdy3)
        begin
            rsum_reg  <= rsum_next;
            ctrl3_reg <= ctrl2_reg;
        end
        if (rdy4)
        begin
            sum_reg   <= sum_next;
            ctrl4_reg <= ctrl3_reg;
        end
        if (rdy5)
        begin
            mul_reg   <= mul_next;
            ctrl5_reg <= ctrl4_reg;
        end
        if (rdy6)
        begin
            pix_reg   <= pix_next;
            ctrl6_reg <= ctrl5_reg;
        end
    end

    assign results.valid        = v6_reg;
    assign results.pixel_out    = pix_reg;
    assign results.end_of_line  = ctrl6_reg.eol;
    assign results.end_of_frame = ctrl6_reg.eof;

endmodule

// ===== rtl/image_convolution_5x5_clamped.sv =====
// Top level of the streaming KxK convolution with clamped output.
// Depends on imconv5_pkg, imconv5_if, imconv5_ram and imconv5_filter.
//
//   port     role   payload                                  handshake
//   -------  -----  ---------------------------------------  -----------
//   cfg      sink   index (3), data (40)                     valid/ready
//   pixels   sink   op (1), pixel_in (8)                     valid/ready
//   results  source pixel_out (8), end_of_line, end_of_frame valid/ready
//
// One request per clock while results are taken; a result passes the request stage and then
// the filter registers. The line memory has one read and one write port;
// a request that hits the column written in the same cycle takes forwarded data.
// Reset (rst_n, async) loads the Gaussian kernel and clears counters and valid bits;
// the line memory needs no clearing. Requests stall only when the result register
// and the stages behind it are full. cfg is always ready.
module image_convolution_5x5_clamped #(
    parameter int MAX_WIDTH   = 1024,
    parameter int MAX_HEIGHT  = 1024,
    parameter int KERNEL_SIZE = 5,
    parameter int COEF_BITS   = 8
) (
    input  logic              clk,
    input  logic              rst_n,
    imconv5_cfg_if.sink       cfg,
    imconv5_in_if.sink        pixels,
    imconv5_out_if.source     results
);

    localparam int PIX_W   = imconv5_pkg::PIX_W;
    localparam int SIZE_W  = imconv5_pkg::SIZE_W;
    localparam int COUNT_W = imconv5_pkg::COUNT_W;
    localparam int HALF    = KERNEL_SIZE / 2;
    localparam int LINES   = KERNEL_SIZE - 1;
    localparam int LINE_W  = LINES * PIX_W;
    localparam int COL_W   = $clog2(MAX_WIDTH);
    localparam int ROW_W   = $clog2(MAX_HEIGHT);
    localparam int WD_W    = $clog2(MAX_WIDTH + 1);
    localparam int HT_W    = $clog2(MAX_HEIGHT + 1);
    localparam int WC_W    = ((WD_W > SIZE_W) ? WD_W : SIZE_W) + 1;
    localparam int HC_W    = ((HT_W > SIZE_W) ? HT_W : SIZE_W) + 1;
    localparam int THR_W   = WD_W + 2;
    localparam int MW_W    = WD_W + 2;
    localparam int MH_W    = HT_W + 2;

    // Configuration registers
    imconv5_pkg::krows_t                krow_reg;
    logic [imconv5_pkg::SCALE_W-1:0]    scale_reg;
    logic [SIZE_W-1:0]                  width_reg;
    logic [SIZE_W-1:0]                  height_reg;

    // Stream counters
    logic [COL_W-1:0]   col_reg;
    logic [COUNT_W-1:0] count_reg;
    logic [COL_W-1:0]   out_col_reg;
    logic [ROW_W-1:0]   out_row_reg;

    // Request stage (memory read in flight)
    logic                   v1_reg;
    logic [PIX_W-1:0]       px1_reg;
    logic [COL_W-1:0]       col1_reg;
    logic                   emit1_reg;
    imconv5_pkg::res_ctrl_t ctrl1_reg;
    logic [KERNEL_SIZE-1:0] rmask1_reg;
    logic [KERNEL_SIZE-1:0] cmask1_reg;
    logic                   fwd_reg;
    logic [LINE_W-1:0]      fwd_data_reg;

    logic [KERNEL_SIZE-1:0][KERNEL_SIZE-1:0][PIX_W-1:0] win_reg;
    logic [KERNEL_SIZE-1:0][KERNEL_SIZE-1:0][PIX_W-1:0] win_next;
    logic [KERNEL_SIZE-1:0][KERNEL_SIZE-1:0][PIX_W-1:0] win_masked;

    logic [WD_W-1:0]        w_eff;
    logic [HT_W-1:0]        h_eff;
    logic [THR_W-1:0]       thr;
    logic                   emit;
    logic                   col_wrap;
    logic                   eol;
    logic                   eof;
    logic [KERNEL_SIZE-1:0] rmask;
    logic [KERNEL_SIZE-1:0] cmask;
    logic [MH_W-1:0]        rpos;
    logic [MW_W-1:0]        cpos;
    logic [PIX_W-1:0]       px;
    logic                   acc;
    logic                   ready1;
    logic                   adv1;
    logic                   filt_ready;
    logic [LINE_W-1:0]      ram_rdata;
    logic [LINE_W-1:0]      line_data;
    logic [LINE_W-1:0]      line_wdata;
    imconv5_pkg::res_ctrl_t ctrl;

    // Config writes are taken in every cycle
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            krow_reg[0] <= imconv5_pkg::KROW_EDGE_RST;
            krow_reg[1] <= imconv5_pkg::KROW_INNER_RST;
            krow_reg[2] <= imconv5_pkg::KROW_CENTER_RST;
            krow_reg[3] <= imconv5_pkg::KROW_INNER_RST;
            krow_reg[4] <= imconv5_pkg::KROW_EDGE_RST;
            scale_reg   <= imconv5_pkg::SCALE_RST;
            width_reg   <= imconv5_pkg::SIZE_RST;
            height_reg  <= imconv5_pkg::SIZE_RST;
        end
        else if (cfg.valid)
        begin
            case (imconv5_pkg::reg_index_t'(cfg.index))
                imconv5_pkg::REG_KROW0:  krow_reg[0] <= cfg.data;
                imconv5_pkg::REG_KROW1:  krow_reg[1] <= cfg.data;
                imconv5_pkg::REG_KROW2:  krow_reg[2] <= cfg.data;
                imconv5_pkg::REG_KROW3:  krow_reg[3] <= cfg.data;
                imconv5_pkg::REG_KROW4:  krow_reg[4] <= cfg.data;
                imconv5_pkg::REG_SCALE:  scale_reg   <= cfg.data[imconv5_pkg::SCALE_W-1:0];
                imconv5_pkg::REG_WIDTH:  width_reg   <= cfg.data[SIZE_W-1:0];
                imconv5_pkg::REG_HEIGHT: height_reg  <= cfg.data[SIZE_W-1:0];
                default: ;
            endcase
        end
    end

    // Effective frame size: zero acts as one, oversize acts as the maximum
    always_comb
    begin
        if (width_reg == '0)
            w_eff = WD_W'(1);
        else if (WC_W'(width_reg) > WC_W'(MAX_WIDTH))
            w_eff = WD_W'(MAX_WIDTH);
        else
            w_eff = WD_W'(width_reg);

        if (height_reg == '0)
            h_eff = HT_W'(1);
        else if (HC_W'(height_reg) > HC_W'(MAX_HEIGHT))
            h_eff = HT_W'(MAX_HEIGHT);
        else
            h_eff = HT_W'(height_reg);
    end

    // Handshake of the request stage
    assign ready1        = !v1_reg || filt_ready;
    assign adv1          = v1_reg && filt_ready;
    assign pixels.ready  = ready1;
    assign acc           = pixels.valid && ready1;
    assign px            = (pixels.op == imconv5_pkg::OP_FLUSH) ? '0 : pixels.pixel_in;

    // Result decision and position of the next result
    assign thr      = THR_W'(HALF) * THR_W'(w_eff) + THR_W'(HALF);
    assign emit     = count_reg >= COUNT_W'(thr);
    assign col_wrap = (WD_W'(col_reg) + WD_W'(1)) >= w_eff;
    assign eol      = (WD_W'(out_col_reg) + WD_W'(1)) >= w_eff;
    assign eof      = eol && ((HT_W'(out_row_reg) + HT_W'(1)) >= h_eff);

    // Mask rows and columns of the window that fall outside the frame
    always_comb
    begin
        rpos = '0;
        cpos = '0;
        for (int i = 0; i < KERNEL_SIZE; i++)
        begin
            rpos     = MH_W'(out_row_reg) + MH_W'(i);
            rmask[i] = (rpos >= MH_W'(HALF)) && (rpos < MH_W'(h_eff) + MH_W'(HALF));
            cpos     = MW_W'(out_col_reg) + MW_W'(i);
            cmask[i] = (cpos >= MW_W'(HALF)) && (cpos < MW_W'(w_eff) + MW_W'(HALF));
        end
    end

    // Advance stream counters on each request
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg     <= '0;
            count_reg   <= '0;
            out_col_reg <= '0;
            out_row_reg <= '0;
        end
        else if (acc)
        begin
            if (emit && eof)
            begin
                col_reg     <= '0;
                count_reg   <= '0;
                out_col_reg <= '0;
                out_row_reg <= '0;
            end
            else
            begin
                col_reg <= col_wrap ? '0 : col_reg + COL_W'(1);
                if (count_reg != '1)
                begin
                    count_reg <= count_reg + COUNT_W'(1);
                end
                if (emit)
                begin
                    if (eol)
                    begin
                        out_col_reg <= '0;
                        out_row_reg <= out_row_reg + ROW_W'(1);
                    end
                    else
                    begin
                        out_col_reg <= out_col_reg + COL_W'(1);
                    end
                end
            end
        end
    end

    // Request stage control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg  <= 1'b0;
            fwd_reg <= 1'b0;
        end
        else
        begin
            if (ready1)
            begin
                v1_reg <= pixels.valid;
            end
            if (acc)
            begin
                fwd_reg <= adv1 && (col_reg == col1_reg);
            end
        end
    end

    // Request stage payload and forwarded line data
    always_ff @(posedge clk)
    begin
        if (acc)
        begin
            px1_reg      <= px;
            col1_reg     <= col_reg;
            emit1_reg    <= emit;
            ctrl1_reg    <= '{eol: eol, eof: eof};
            rmask1_reg   <= rmask;
            cmask1_reg   <= cmask;
            fwd_data_reg <= line_wdata;
        end
    end

    // Column of older lines: take the write of the previous request if it hit this column
    assign line_data  = fwd_reg ? fwd_data_reg : ram_rdata;
    // Push the new pixel into line 0, move every line one step down
    assign line_wdata = {line_data[LINE_W-PIX_W-1:0], px1_reg};

    imconv5_ram #(
        .DATA_W (LINE_W),
        .DEPTH  (MAX_WIDTH)
    ) u_line_ram (
        .clk    (clk),
        .we     (adv1),
        .waddr  (col1_reg),
        .wdata  (line_wdata),
        .re     (acc),
        .raddr  (col_reg),
        .rdata  (ram_rdata)
    );

    // Shift the window left and load the new column
    always_comb
    begin
        for (int i = 0; i < KERNEL_SIZE; i++)
        begin
            for (int k = 0; k < KERNEL_SIZE - 1; k++)
            begin
                win_next[i][k] = win_reg[i][k+1];
            end
        end
        for (int i = 0; i < KERNEL_SIZE - 1; i++)
        begin
            win_next[i][KERNEL_SIZE-1] = line_data[PIX_W*(KERNEL_SIZE-2-i) +: PIX_W];
        end
        win_next[KERNEL_SIZE-1][KERNEL_SIZE-1] = px1_reg;
    end

    // Zero taps outside the frame
    always_comb
    begin
        for (int i = 0; i < KERNEL_SIZE; i++)
        begin
            for (int k = 0; k < KERNEL_SIZE; k++)
            begin
                win_masked[i][k] = (rmask1_reg[i] && cmask1_reg[k]) ? win_next[i][k] : '0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv1)
        begin
            win_reg <= win_next;
        end
    end

    assign ctrl = ctrl1_reg;

    imconv5_filter #(
        .KERNEL_SIZE (KERNEL_SIZE),
        .COEF_BITS   (COEF_BITS)
    ) u_filter (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (adv1 && emit1_reg),
        .ready   (filt_ready),
        .win     (win_masked),
        .ctrl    (ctrl),
        .krows   (krow_reg),
        .scale   (scale_reg),
        .results (results)
    );

`ifndef SYNTHESIS
    // Frame end returns all stream counters to the start
    a_frame_restart: assert property (@(posedge clk) disable iff (!rst_n)
        (acc && emit && eof) |=> (count_reg == '0 && col_reg == '0 &&
                                  out_col_reg == '0 && out_row_reg == '0))
        else $error("counters not cleared after frame end");

    // A read that collides with the write-back must pick up forwarded data
    a_forward: assert property (@(posedge clk) disable iff (!rst_n)
        (acc && adv1 && (col_reg == col1_reg)) |=> fwd_reg)
        else $error("missed forwarding on same-column access");

    // Last pixel of a frame is also last of its line
    a_eof_eol: assert property (@(posedge clk) disable iff (!rst_n)
        (results.valid && results.end_of_frame) |-> results.end_of_line)
        else $error("end_of_frame without end_of_line");

    // An empty request stage always accepts a new request
    a_no_stall_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (!v1_reg) |-> pixels.ready)
        else $error("request refused with empty request stage");
`endif

endmodule

// ===== verif/image_convolution_5x5_clamped_test.sv =====
// Self-checking testbench for the streaming 5x5 convolution with clamped output.
// Depends on imconv5_pkg, the imconv5 channel interfaces and the block's top level;
// predicts each filtered pixel from the accepted request stream and register writes.
module image_convolution_5x5_clamped_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int PIX_W      = imconv5_pkg::PIX_W;
    localparam int BYTE_W     = imconv5_pkg::BYTE_W;
    localparam int KROW_W     = imconv5_pkg::KROW_W;
    localparam int NUM_KROWS  = imconv5_pkg::NUM_KROWS;
    localparam int SCALE_W    = imconv5_pkg::SCALE_W;
    localparam int FRAC_W     = imconv5_pkg::FRAC_W;
    localparam int SIZE_W     = imconv5_pkg::SIZE_W;
    localparam int COUNT_W    = imconv5_pkg::COUNT_W;
    localparam int CFG_DATA_W = imconv5_pkg::CFG_DATA_W;

    localparam int          MAX_DIM      = 1024;
    localparam int          KSIZE        = 5;
    localparam int          HALF         = KSIZE / 2;
    localparam int          LINES        = KSIZE - 1;
    localparam int unsigned COUNT_MAX    = (1 << COUNT_W) - 1;
    localparam int          DRAIN_CYCLES = 20;
    localparam int          TIMEOUT_NS   = 8_000_000;

    // Idle modes of a phase
    localparam int IDLE_NONE = 0;
    localparam int IDLE_SEND = 1;
    localparam int IDLE_RECV = 2;
    localparam int IDLE_BOTH = 3;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    int          send_idle_pct  = 0;
    int          recv_stall_pct = 0;
    int unsigned items_sent     = 0;

    imconv5_cfg_if cfg_if ();
    imconv5_in_if  pix_if ();
    imconv5_out_if res_if ();

    image_convolution_5x5_clamped u_top (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg_if),
        .pixels  (pix_if),
        .results (res_if)
    );

    typedef struct packed {
        logic [PIX_W-1:0] pixel;
        logic             eol;
        logic             eof;
    } conv_result_t;

    // Mirror of the filter state; turns accepted requests into expected pixels
    class conv_result_tracker;
        logic [KROW_W-1:0]  kernel [NUM_KROWS];
        logic [SCALE_W-1:0] scale;
        logic [SIZE_W-1:0]  width_reg;
        logic [SIZE_W-1:0]  height_reg;
        bit [PIX_W-1:0]     line_mem [LINES][MAX_DIM];
        bit [PIX_W-1:0]     win [KSIZE][KSIZE];
        int unsigned        item_count;
        int unsigned        in_col;
        int unsigned        out_col;
        int unsigned        out_row;
        conv_result_t       filtered_q [$];
        int                 mismatch_count;

        function new();
            kernel[0]      = imconv5_pkg::KROW_EDGE_RST;
            kernel[1]      = imconv5_pkg::KROW_INNER_RST;
            kernel[2]      = imconv5_pkg::KROW_CENTER_RST;
            kernel[3]      = imconv5_pkg::KROW_INNER_RST;
            kernel[4]      = imconv5_pkg::KROW_EDGE_RST;
            scale          = imconv5_pkg::SCALE_RST;
            width_reg      = imconv5_pkg::SIZE_RST;
            height_reg     = imconv5_pkg::SIZE_RST;
            item_count     = 0;
            in_col         = 0;
            out_col        = 0;
            out_row        = 0;
            mismatch_count = 0;
        endfunction

        // Zero acts as one, oversize acts as the maximum
        function int unsigned eff_dim(logic [SIZE_W-1:0] v);
            if (v == 0)
                return 1;
            if (v > MAX_DIM)
                return MAX_DIM;
            return v;
        endfunction

        function int unsigned frame_width();
            return eff_dim(width_reg);
        endfunction

        function int unsigned frame_height();
            return eff_dim(height_reg);
        endfunction

        function bit at_frame_start();
            return item_count == 0;
        endfunction

        function int pending();
            return filtered_q.size();
        endfunction

        function void write_reg(imconv5_pkg::reg_index_t idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                imconv5_pkg::REG_KROW0, imconv5_pkg::REG_KROW1, imconv5_pkg::REG_KROW2,
                imconv5_pkg::REG_KROW3, imconv5_pkg::REG_KROW4:
                    kernel[int'(idx)] = data[KROW_W-1:0];
                imconv5_pkg::REG_SCALE:  scale      = data[SCALE_W-1:0];
                imconv5_pkg::REG_WIDTH:  width_reg  = data[SIZE_W-1:0];
                imconv5_pkg::REG_HEIGHT: height_reg = data[SIZE_W-1:0];
                default: ;
            endcase
        endfunction

        function void take_pixel(imconv5_pkg::op_t op, logic [PIX_W-1:0] px);
            int unsigned  w;
            int unsigned  h;
            int unsigned  col;
            int unsigned  n;
            bit [PIX_W-1:0] v;
            longint       acc;
            bit [63:0]    scaled;
            int           rr;
            int           cc;
            int           coef;
            conv_result_t r;

            w   = frame_width();
            h   = frame_height();
            v   = (op == imconv5_pkg::OP_FLUSH) ? '0 : px;
            col = (in_col < MAX_DIM) ? in_col : 0;
            n   = item_count;

            // Shift the window left and load the new column from the line memory
            for (int i = 0; i < KSIZE; i++)
                for (int k = 0; k < KSIZE - 1; k++)
                    win[i][k] = win[i][k+1];
            for (int i = 0; i < LINES; i++)
                win[i][KSIZE-1] = line_mem[LINES-1-i][col];
            win[KSIZE-1][KSIZE-1] = v;

            // Push the column of the line memory down by one line
            for (int l = LINES - 1; l > 0; l--)
                line_mem[l][col] = line_mem[l-1][col];
            line_mem[0][col] = v;

            in_col = (col + 1 >= w) ? 0 : col + 1;
            if (item_count < COUNT_MAX)
                item_count++;

            if (n < HALF * w + HALF)
                return;

            // Weighted sum over the taps that fall inside the frame
            acc = 0;
            for (int i = 0; i < KSIZE; i++)
            begin
                rr = int'(out_row) - HALF + i;
                if (rr < 0 || rr >= int'(h))
                    continue;
                for (int k = 0; k < KSIZE; k++)
                begin
                    cc = int'(out_col) - HALF + k;
                    if (cc < 0 || cc >= int'(w))
                        continue;
                    coef = $signed(kernel[i][BYTE_W*k +: BYTE_W]);
                    acc += longint'(win[i][k]) * coef;
                end
            end

            if (acc <= 0)
            begin
                r.pixel = '0;
            end
            else
            begin
                scaled  = ($unsigned(acc) * scale) >> FRAC_W;
                r.pixel = (scaled > imconv5_pkg::PIX_MAX) ? imconv5_pkg::PIX_MAX
                                                          : scaled[PIX_W-1:0];
            end
            r.eol = (out_col + 1 >= w);
            r.eof = r.eol && (out_row + 1 >= h);
            filtered_q = {filtered_q, r};

            // Advance the output position; a frame end restarts all counters
            if (r.eof)
            begin
                item_count = 0;
                in_col     = 0;
                out_col    = 0;
                out_row    = 0;
            end
            else if (r.eol)
            begin
                out_col = 0;
                out_row++;
            end
            else
            begin
                out_col++;
            end
        endfunction

        task report(string msg);
            mismatch_count++;
            $display("[%0t] mismatch: %s", $time, msg);
        endtask

        task match_result(logic [PIX_W-1:0] pix, logic eol, logic eof);
            conv_result_t want;

            if (filtered_q.size() == 0)
            begin
                report($sformatf("result pixel=%0d with nothing outstanding", pix));
                return;
            end
            want = filtered_q.pop_front();
            if (pix !== want.pixel)
                report($sformatf("pixel_out %0d, predicted %0d", pix, want.pixel));
            if (eol !== want.eol)
                report($sformatf("end_of_line %b, predicted %b", eol, want.eol));
            if (eof !== want.eof)
                report($sformatf("end_of_frame %b, predicted %b", eof, want.eof));
        endtask
    endclass

    conv_result_tracker tracker = new();

    // Clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Hard limit on the run
    initial
    begin
        #(TIMEOUT_NS);
        $display("TB_ERROR");
        $finish;
    end

    // Result side: check accepted results, then pick the next ready
    initial
    begin
        res_if.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && res_if.valid && res_if.ready)
                tracker.match_result(res_if.pixel_out, res_if.end_of_line,
                                     res_if.end_of_frame);
            res_if.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    function automatic logic [PIX_W-1:0] rand_pixel();
        case ($urandom_range(0, 5))
            0:       return '0;
            1:       return imconv5_pkg::PIX_MAX;
            default: return PIX_W'($urandom);
        endcase
    endfunction

    // Mix full-range coefficients with small non-negative ones
    function automatic logic [KROW_W-1:0] rand_krow();
        logic [KROW_W-1:0] row;

        for (int k = 0; k < KSIZE; k++)
            row[BYTE_W*k +: BYTE_W] = $urandom_range(0, 1) ? BYTE_W'($urandom)
                                                           : BYTE_W'($urandom_range(0, 20));
        return row;
    endfunction

    function automatic logic [SIZE_W-1:0] rand_dim();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return SIZE_W'($urandom_range(9, 16));
            default: return SIZE_W'($urandom_range(1, 8));
        endcase
    endfunction

    // Send one pixel request, with random gaps ahead of it
    task automatic send_item(imconv5_pkg::op_t op, logic [PIX_W-1:0] px);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            pix_if.valid <= 1'b0;
            @(posedge clk);
        end
        pix_if.valid    <= 1'b1;
        pix_if.op       <= op;
        pix_if.pixel_in <= px;
        do
            @(posedge clk);
        while (!pix_if.ready);
        tracker.take_pixel(op, px);
        items_sent++;
    endtask

    // Write one register; valid stays high until the caller drops it
    task automatic write_reg(imconv5_pkg::reg_index_t idx, logic [CFG_DATA_W-1:0] data);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data  <= data;
        do
            @(posedge clk);
        while (!cfg_if.ready);
        tracker.write_reg(idx, data);
    endtask

    // Hold requests until every predicted result has come out
    task automatic hold_until_drained();
        pix_if.valid <= 1'b0;
        do
            @(posedge clk);
        while (tracker.pending() != 0);
    endtask

    // Drain, then let requests that make no result clear the pipeline
    task automatic quiesce();
        hold_until_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic begin_phase(int mode);
        cfg_if.valid <= 1'b0;
        case (mode)
            IDLE_SEND:
            begin
                send_idle_pct  = 73;
                recv_stall_pct = 0;
            end
            IDLE_RECV:
            begin
                send_idle_pct  = 0;
                recv_stall_pct = 73;
            end
            IDLE_BOTH:
            begin
                send_idle_pct  = 20;
                recv_stall_pct = 20;
            end
            default:
            begin
                send_idle_pct  = 0;
                recv_stall_pct = 0;
            end
        endcase
    endtask

    task automatic write_random_coefs(bit all);
        for (int r = 0; r < NUM_KROWS; r++)
            if (all || $urandom_range(0, 1))
                write_reg(imconv5_pkg::reg_index_t'(r), CFG_DATA_W'(rand_krow()));
        if (all || $urandom_range(0, 1))
            case ($urandom_range(0, 5))
                0:       write_reg(imconv5_pkg::REG_SCALE, '0);
                1:       write_reg(imconv5_pkg::REG_SCALE, CFG_DATA_W'(65536));
                2:       write_reg(imconv5_pkg::REG_SCALE, CFG_DATA_W'({SCALE_W{1'b1}}));
                3:       write_reg(imconv5_pkg::REG_SCALE, CFG_DATA_W'(imconv5_pkg::SCALE_RST));
                4:       write_reg(imconv5_pkg::REG_SCALE,
                                   CFG_DATA_W'($urandom_range(0, 65536)));
                default: write_reg(imconv5_pkg::REG_SCALE,
                                   CFG_DATA_W'($urandom_range(64, 2048)));
            endcase
    endtask

    // One frame plus its flush requests; a broken frame may swap kinds and
    // change its length
    task automatic send_frame(bit broken, bit pause);
        int unsigned      w;
        int unsigned      h;
        int unsigned      total;
        imconv5_pkg::op_t op;

        w     = tracker.frame_width();
        h     = tracker.frame_height();
        total = w * h + HALF * w + HALF;
        if (broken)
            total = total - $urandom_range(0, HALF * w + 1) + $urandom_range(0, 3);
        for (int unsigned i = 0; i < total; i++)
        begin
            op = (i < w * h) ? imconv5_pkg::OP_PIXEL : imconv5_pkg::OP_FLUSH;
            if (broken && $urandom_range(0, 7) == 0)
                op = (op == imconv5_pkg::OP_PIXEL) ? imconv5_pkg::OP_FLUSH
                                                   : imconv5_pkg::OP_PIXEL;
            send_item(op, rand_pixel());
            if (pause && i + 3 == total)
                hold_until_drained();
        end
    endtask

    // Flush until the predicted stream is back at a frame start
    task automatic close_frame();
        while (!tracker.at_frame_start())
            send_item(imconv5_pkg::OP_FLUSH, rand_pixel());
    endtask

    // Stimulus
    initial
    begin
        logic [PIX_W-1:0] first_pix [17];
        int unsigned      target;
        bit               first;
        imconv5_pkg::op_t op;

        first_pix = '{8'd0, 8'd255, 8'd128, 8'd1, 8'd255,
                      8'd255, 8'd7, 8'd200, 8'd64, 8'd0,
                      8'd0, 8'd0, 8'd255, 8'd0, 8'd0,
                      8'd0, 8'd0};

        pix_if.valid    <= 1'b0;
        pix_if.op       <= imconv5_pkg::OP_PIXEL;
        pix_if.pixel_in <= '0;
        cfg_if.valid    <= 1'b0;
        cfg_if.index    <= imconv5_pkg::REG_KROW0;
        cfg_if.data     <= '0;

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset kernel on a 3x3 frame: a flush in a pixel slot, a pixel in a flush slot
        write_reg(imconv5_pkg::REG_WIDTH, CFG_DATA_W'(3));
        write_reg(imconv5_pkg::REG_HEIGHT, CFG_DATA_W'(3));
        begin_phase(IDLE_NONE);
        for (int i = 0; i < 17; i++)
        begin
            op = (i < 9) ? imconv5_pkg::OP_PIXEL : imconv5_pkg::OP_FLUSH;
            if (i == 4)
                op = imconv5_pkg::OP_FLUSH;
            if (i == 12)
                op = imconv5_pkg::OP_PIXEL;
            send_item(op, first_pix[i]);
        end

        // Largest positive kernel, full scale, zero sizes: clamps high
        quiesce();
        for (int r = 0; r < NUM_KROWS; r++)
            write_reg(imconv5_pkg::reg_index_t'(r), CFG_DATA_W'(40'h7F7F7F7F7F));
        write_reg(imconv5_pkg::REG_SCALE, CFG_DATA_W'(65536));
        write_reg(imconv5_pkg::REG_WIDTH, '0);
        write_reg(imconv5_pkg::REG_HEIGHT, '0);
        begin_phase(IDLE_NONE);
        send_item(imconv5_pkg::OP_PIXEL, imconv5_pkg::PIX_MAX);
        close_frame();

        // Most negative kernel, oversized scale: negative sum clamps to zero
        quiesce();
        for (int r = 0; r < NUM_KROWS; r++)
            write_reg(imconv5_pkg::reg_index_t'(r), CFG_DATA_W'(40'h8080808080));
        write_reg(imconv5_pkg::REG_SCALE, CFG_DATA_W'({SCALE_W{1'b1}}));
        write_reg(imconv5_pkg::REG_WIDTH, CFG_DATA_W'(1));
        write_reg(imconv5_pkg::REG_HEIGHT, CFG_DATA_W'(1));
        begin_phase(IDLE_NONE);
        send_item(imconv5_pkg::OP_PIXEL, imconv5_pkg::PIX_MAX);
        close_frame();

        // Oversized height on a one-column frame, then shrink it inside the frame
        quiesce();
        write_random_coefs(1'b1);
        write_reg(imconv5_pkg::REG_WIDTH, CFG_DATA_W'(1));
        write_reg(imconv5_pkg::REG_HEIGHT, CFG_DATA_W'(2047));
        begin_phase(IDLE_RECV);
        for (int i = 0; i < 60; i++)
            send_item(imconv5_pkg::OP_PIXEL, rand_pixel());
        quiesce();
        write_reg(imconv5_pkg::REG_HEIGHT, CFG_DATA_W'(2));
        begin_phase(IDLE_NONE);
        close_frame();

        // Random phases of small frames, mostly well formed
        for (int p = 0; p < 8; p++)
        begin
            quiesce();
            write_random_coefs(p == 0);
            write_reg(imconv5_pkg::REG_WIDTH, CFG_DATA_W'(rand_dim()));
            write_reg(imconv5_pkg::REG_HEIGHT, CFG_DATA_W'(rand_dim()));
            begin_phase(p % 4);
            target = items_sent + 40;
            first  = 1'b1;
            while (items_sent < target)
            begin
                send_frame($urandom_range(0, 99) < 15, first && (p == 1));
                first = 1'b0;
            end
            close_frame();
        end

        quiesce();
        if (tracker.mismatch_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
